[rtl/bb3_pkg.sv]
// bb3_pkg: shared types, constants and the divide-by-nine helper for the 3x3 box blur
// no dependencies; used by every rtl file of the blur block
`default_nettype none

package bb3_pkg;

	localparam int PIX_W      = 32;
	localparam int RGB_W      = 24;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 12;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_W      = 13;
	localparam int DIV9_MUL_W = 13;
	localparam int PROD_W     = SUM_W + DIV9_MUL_W;
	localparam int DIV9_SHIFT = 16;

	localparam int RESET_WIDTH  = 800;
	localparam int RESET_HEIGHT = 600;

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [CH_W-1:0]       ALPHA_OPAQUE = 8'hFF;
	// ceil(2^16 / 9); exact floor for sums up to 9 * 255
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL     = 13'd7282;

	typedef logic [RGB_W-1:0] bb3_rgb_t;
	typedef logic [SUM_W-1:0] bb3_sum_t;

	typedef struct packed {
		logic emit;
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bottom_ok;
		logic done;
	} bb3_flags_t;

	function automatic logic [CH_W-1:0] div9(input bb3_sum_t s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(DIV9_MUL);
		return p[DIV9_SHIFT +: CH_W];
	endfunction

endpackage

`default_nettype wire

[rtl/bb3_line_store.sv]
// bb3_line_store: one memory holding the two previous rows per column, read-modify-write
// depends on bb3_pkg; registered read, forwarding for back-to-back same-column access
`default_nettype none

module bb3_line_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire                  clk,
	input  wire                  rd_en,
	input  wire [ADDR_W-1:0]     rd_addr,
	input  bb3_pkg::bb3_rgb_t    rgb_in,
	input  wire                  adv,
	output bb3_pkg::bb3_rgb_t    upper,
	output bb3_pkg::bb3_rgb_t    middle,
	output bb3_pkg::bb3_rgb_t    bottom
);

	// entry: upper row in the high half, middle row in the low half
	logic [2*bb3_pkg::RGB_W-1:0] mem [DEPTH];
	logic [2*bb3_pkg::RGB_W-1:0] rd_q;
	logic [2*bb3_pkg::RGB_W-1:0] fwd_s1;
	logic [ADDR_W-1:0]           addr_s1;
	bb3_pkg::bb3_rgb_t           rgb_s1;
	logic                        hz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mem[addr_s1] <= {middle, rgb_s1};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
			rgb_s1  <= rgb_in;
			// previous item writes this column in the same cycle
			hz_s1   <= adv && (addr_s1 == rd_addr);
			fwd_s1  <= {middle, rgb_s1};
		end
	end

	assign {upper, middle} = hz_s1 ? fwd_s1 : rd_q;
	assign bottom          = rgb_s1;

endmodule

`default_nettype wire

[rtl/bb3_window.sv]
// bb3_window: 3x3 window of pixel columns and the registered masked channel sums
// depends on bb3_pkg; shifts one column per item, sums use the frame-edge flags
`default_nettype none

module bb3_window (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  shift,
	input  bb3_pkg::bb3_rgb_t    upper,
	input  bb3_pkg::bb3_rgb_t    middle,
	input  bb3_pkg::bb3_rgb_t    bottom,
	input  wire                  load,
	input  bb3_pkg::bb3_flags_t  flags,
	output bb3_pkg::bb3_sum_t    sum_s3 [3]
);

	// [column: left, centre, right][row: top, mid, bottom]
	bb3_pkg::bb3_rgb_t win_q [3][3];
	bb3_pkg::bb3_sum_t sum_d [3];
	logic              col_ok [3];
	logic              row_ok [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else if (shift) begin
			for (int j = 0; j < 3; j++) begin
				win_q[0][j] <= win_q[1][j];
				win_q[1][j] <= win_q[2][j];
			end
			win_q[2][0] <= upper;
			win_q[2][1] <= middle;
			win_q[2][2] <= bottom;
		end
	end

	always_comb begin
		col_ok[0] = flags.left_ok;
		col_ok[1] = 1'b1;
		col_ok[2] = flags.right_ok;
		row_ok[0] = flags.top_ok;
		row_ok[1] = 1'b1;
		row_ok[2] = flags.bottom_ok;
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					if (col_ok[k] && row_ok[j]) begin
						sum_d[ch] = sum_d[ch] + bb3_pkg::SUM_W'(
							win_q[k][j][bb3_pkg::RGB_W-1-bb3_pkg::CH_W*ch -: bb3_pkg::CH_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s3[ch] <= sum_d[ch];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/box_blur_3x3_rgb_unit.sv]
// box_blur_3x3_rgb_unit: streaming 3x3 box blur of one rgba8888 frame, top level
// depends on bb3_pkg, bb3_line_store and bb3_window
//
//  channel  | dir | handshake                  | word contents (lowest bit up)
//  s_axis   | in  | s_axis_tvalid/tready       | tdata: in_pixel[31:0]; tuser: is_flush
//  m_axis   | out | m_axis_tvalid/tready       | tdata: out_pixel, out_column, out_row, zero pad;
//           |     |                            | tlast: frame_done
//  cfg      | in  | cfg_we (no wait)           | cfg_index selects register, cfg_data value
//
// one word per clock sustained while m_axis is ready; the line store memory is read at accept
// and written back as the word leaves stage one, so each word costs one read and one write
// a centre's trigger word reaches m_axis through stages one to three and the output register
// arst_n clears control and position; line store contents are undefined and masked by row
// a stalled m_axis backs up through the four stages before s_axis_tready drops
`default_nettype none

module box_blur_3x3_rgb_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W     = $clog2(MAX_WIDTH),
	localparam int ROW_W     = $clog2(MAX_HEIGHT),
	localparam int OUT_W     = ((bb3_pkg::PIX_W + COL_W + ROW_W + 7) / 8) * 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// input stream
	input  wire                        s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire [bb3_pkg::PIX_W-1:0]   s_axis_tdata,   // in_pixel
	input  wire                        s_axis_tuser,   // is_flush
	// output stream
	output logic                       m_axis_tvalid,
	input  wire                        m_axis_tready,
	output logic [OUT_W-1:0]           m_axis_tdata,   // out_pixel, out_column, out_row, pad
	output logic                       m_axis_tlast,   // frame_done
	// configuration
	input  wire                        cfg_we,
	input  wire                        cfg_index,
	input  wire [bb3_pkg::CFG_W-1:0]   cfg_data
);

	localparam int RPOS_W = $clog2(MAX_HEIGHT + 2);  // row runs to height+1 while draining
	localparam int WE_W   = $clog2(MAX_WIDTH + 1);
	localparam int HE_W   = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST  = (bb3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
	                                                           : bb3_pkg::RESET_WIDTH;
	localparam int H_RST  = (bb3_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
	                                                             : bb3_pkg::RESET_HEIGHT;

	// effective (clamped) frame size
	logic [WE_W-1:0]   width_q;
	logic [HE_W-1:0]   height_q;
	logic [bb3_pkg::FW_W-1:0] cfg_fw;
	logic [bb3_pkg::FH_W-1:0] cfg_fh;
	logic [WE_W-1:0]   width_clamped;
	logic [HE_W-1:0]   height_clamped;

	// position of the next arriving word
	logic [COL_W-1:0]  pos_col_q;
	logic [RPOS_W-1:0] pos_row_q;

	// accept stage
	logic              in_acc;
	logic [WE_W-1:0]   width_dec;
	logic [COL_W-1:0]  w_m1;
	logic [RPOS_W-1:0] h_ext;
	logic [RPOS_W-1:0] h_m1;
	bb3_pkg::bb3_rgb_t rgb_in;
	bb3_pkg::bb3_flags_t flags_in;
	logic [COL_W-1:0]  cc_in;
	logic [RPOS_W-1:0] cr_full;

	// pipeline
	logic              s1_v_q, s2_v_q, s3_v_q, out_v_q;
	bb3_pkg::bb3_flags_t flags_s1, flags_s2;
	logic [COL_W-1:0]  cc_s1, cc_s2, cc_s3;
	logic [ROW_W-1:0]  cr_s1, cr_s2, cr_s3;
	logic              done_s3;
	logic              out_free, s3_free, s2_free;
	logic              s3_adv, s2_adv, s1_adv;

	bb3_pkg::bb3_rgb_t col_upper, col_middle, col_bottom;
	bb3_pkg::bb3_sum_t sum_s3 [3];

	logic [bb3_pkg::PIX_W-1:0] out_pixel_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_last_q;

	// config clamping: zero becomes one, too large saturates
	assign cfg_fw = cfg_data[bb3_pkg::FW_W-1:0];
	assign cfg_fh = cfg_data[bb3_pkg::FH_W-1:0];

	always_comb begin
		if (cfg_fw == '0) begin
			width_clamped = WE_W'(1);
		end else if (int'(cfg_fw) > MAX_WIDTH) begin
			width_clamped = WE_W'(MAX_WIDTH);
		end else begin
			width_clamped = WE_W'(cfg_fw);
		end
		if (cfg_fh == '0) begin
			height_clamped = HE_W'(1);
		end else if (int'(cfg_fh) > MAX_HEIGHT) begin
			height_clamped = HE_W'(MAX_HEIGHT);
		end else begin
			height_clamped = HE_W'(cfg_fh);
		end
	end

	// handshake chain, output register first
	assign out_free      = !out_v_q || m_axis_tready;
	assign s3_adv        = s3_v_q && out_free;
	assign s3_free       = !s3_v_q || out_free;
	// words that complete no centre retire at stage two
	assign s2_adv        = s2_v_q && (!flags_s2.emit || s3_free);
	assign s2_free       = !s2_v_q || s2_adv;
	assign s1_adv        = s1_v_q && s2_free;
	assign s_axis_tready = !s1_v_q || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// accept stage: position bookkeeping and edge flags
	assign width_dec = width_q - WE_W'(1);
	assign w_m1      = width_dec[COL_W-1:0];
	assign h_ext     = RPOS_W'(height_q);
	assign h_m1      = h_ext - RPOS_W'(1);

	always_comb begin
		// flush words and rows past the frame contribute zero
		if (s_axis_tuser || (pos_row_q >= h_ext)) begin
			rgb_in = '0;
		end else begin
			rgb_in = s_axis_tdata[bb3_pkg::PIX_W-1 -: bb3_pkg::RGB_W];
		end

		if (pos_col_q != '0) begin
			flags_in.emit = (pos_row_q != '0);
			cc_in         = pos_col_q - COL_W'(1);
			cr_full       = pos_row_q - RPOS_W'(1);
		end else begin
			// first column completes the last centre of the row before last
			flags_in.emit = (pos_row_q >= RPOS_W'(2));
			cc_in         = w_m1;
			cr_full       = pos_row_q - RPOS_W'(2);
		end
		flags_in.left_ok   = (cc_in != '0);
		flags_in.right_ok  = (cc_in < w_m1);
		flags_in.top_ok    = (cr_full != '0);
		flags_in.bottom_ok = (cr_full < h_m1);
		flags_in.done      = flags_in.emit && (cc_in == w_m1) && (cr_full == h_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WE_W'(W_RST);
			height_q  <= HE_W'(H_RST);
			pos_col_q <= '0;
			pos_row_q <= '0;
		end else if (cfg_we) begin
			// any register write restarts the frame
			case (cfg_index)
				bb3_pkg::CFG_FRAME_WIDTH:  width_q  <= width_clamped;
				bb3_pkg::CFG_FRAME_HEIGHT: height_q <= height_clamped;
				default: ;
			endcase
			pos_col_q <= '0;
			pos_row_q <= '0;
		end else if (in_acc) begin
			if (flags_in.done) begin
				pos_col_q <= '0;
				pos_row_q <= '0;
			end else if (pos_col_q == w_m1) begin
				pos_col_q <= '0;
				pos_row_q <= pos_row_q + RPOS_W'(1);
			end else begin
				pos_col_q <= pos_col_q + COL_W'(1);
			end
		end
	end

	// line store: reads at accept, writes back as the word leaves stage one
	bb3_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (pos_col_q),
		.rgb_in  (rgb_in),
		.adv     (s1_adv),
		.upper   (col_upper),
		.middle  (col_middle),
		.bottom  (col_bottom)
	);

	// window shifts as stage one advances, sums register as stage two advances
	bb3_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (s1_adv),
		.upper  (col_upper),
		.middle (col_middle),
		.bottom (col_bottom),
		.load   (s2_adv && flags_s2.emit),
		.flags  (flags_s2),
		.sum_s3 (sum_s3)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			s3_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_v_q <= s_axis_tvalid;
			end
			if (s2_free) begin
				s2_v_q <= s1_adv;
			end
			if (s3_free) begin
				s3_v_q <= s2_adv && flags_s2.emit;
			end
			if (out_free) begin
				out_v_q <= s3_adv;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_s1 <= flags_in;
			cc_s1    <= cc_in;
			cr_s1    <= cr_full[ROW_W-1:0];
		end
		if (s1_adv) begin
			flags_s2 <= flags_s1;
			cc_s2    <= cc_s1;
			cr_s2    <= cr_s1;
		end
		if (s2_adv && flags_s2.emit) begin
			cc_s3   <= cc_s2;
			cr_s3   <= cr_s2;
			done_s3 <= flags_s2.done;
		end
		if (s3_adv) begin
			// divide by nine regardless of how many neighbours were inside
			out_pixel_q <= {bb3_pkg::div9(sum_s3[0]), bb3_pkg::div9(sum_s3[1]),
			                bb3_pkg::div9(sum_s3[2]), bb3_pkg::ALPHA_OPAQUE};
			out_col_q   <= cc_s3;
			out_row_q   <= cr_s3;
			out_last_q  <= done_s3;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = OUT_W'({out_row_q, out_col_q, out_pixel_q});
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[tb/sv/box_blur_3x3_rgb_unit_test.sv]
// box_blur_3x3_rgb_unit_test: self-checking bench for the streaming 3x3 box blur
// depends on bb3_pkg and box_blur_3x3_rgb_unit; holds its own blur predictor
// reset sizes first, then the directed table, then random frames under random stalls

module box_blur_3x3_rgb_unit_test;

	import bb3_pkg::*;

	localparam int MAX_COLS     = 1024;
	localparam int MAX_ROWS     = 4096;
	localparam int COL_BITS     = $clog2(MAX_COLS);
	localparam int ROW_BITS     = $clog2(MAX_ROWS);
	localparam int OUT_BITS     = ((PIX_W + COL_BITS + ROW_BITS + 7) / 8) * 8;
	// long enough for a trigger word to pass the block's pipe to m_axis
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 100;

	// one blurred word as it leaves the block
	typedef struct packed {
		logic [PIX_W-1:0]    pixel;
		logic [COL_BITS-1:0] column;
		logic [ROW_BITS-1:0] row;
		logic                done;
	} blur_word_t;

	// one line of the directed table: a register write or a pixel, maybe with a typed answer
	typedef struct packed {
		logic             write;
		logic             sel;
		logic [CFG_W-1:0] value;
		logic [PIX_W-1:0] pixel;
		logic             flush;
		logic             typed;
		blur_word_t       want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [PIX_W-1:0]    s_axis_tdata = '0;   // in_pixel
	logic                s_axis_tuser = 1'b0; // is_flush
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;        // out_pixel, out_column, out_row, zero pad
	logic                m_axis_tlast;        // frame_done
	logic                cfg_we = 1'b0;
	logic                cfg_index = 1'b0;
	logic [CFG_W-1:0]    cfg_data = '0;

	box_blur_3x3_rgb_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor state
	logic [FW_W-1:0] width_reg  = FW_W'(RESET_WIDTH);
	logic [FH_W-1:0] height_reg = FH_W'(RESET_HEIGHT);
	bb3_rgb_t        upper_line  [MAX_COLS];
	bb3_rgb_t        middle_line [MAX_COLS];
	bb3_rgb_t        win [3][3];  // [column: left, centre, right][row: top, mid, bottom]
	int              in_col = 0;
	int              in_row = 0;

	blur_word_t      pending_blurs[$];
	int              mismatch_count = 0;
	int              blurs_seen = 0;
	int              cycle_count = 0;
	bit              burst = 1'b0;     // sender runs without gaps while set

	// register values saturate into the supported frame size
	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_COLS) return MAX_COLS;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_ROWS) return MAX_ROWS;
		return int'(height_reg);
	endfunction

	// advance the blur by one accepted pixel; emits is set when a centre completes
	task automatic blur_predict(input logic [PIX_W-1:0] pixel, input logic flush,
			output bit emits, output blur_word_t word);
		int w, h, c, r, cc, cr, sum_r, sum_g, sum_b, k, j;
		bb3_rgb_t rgb, up, mid, nbr;
		w = eff_width();
		h = eff_height();
		c = in_col;
		r = in_row;
		rgb = pixel[PIX_W-1:CH_W];
		// flush items and anything past the last row count as outside
		if (flush || r >= h) rgb = '0;

		up = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = rgb;

		for (k = 0; k < 2; k++)
			for (j = 0; j < 3; j++)
				win[k][j] = win[k+1][j];
		win[2][0] = up;
		win[2][1] = mid;
		win[2][2] = rgb;

		emits = 1'b0;
		cc = 0;
		cr = 0;
		if (c >= 1) begin
			if (r >= 1) begin
				emits = 1'b1;
				cc = c - 1;
				cr = r - 1;
			end
		end else if (r >= 2) begin
			// first column of a row closes the last centre of the row two up
			emits = 1'b1;
			cc = w - 1;
			cr = r - 2;
		end

		c++;
		if (c >= w) begin
			c = 0;
			r++;
		end
		in_col = c;
		in_row = r;

		word = '0;
		if (emits) begin
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			for (k = 0; k < 3; k++) begin
				if (!(k == 0 && cc == 0) && !(k == 2 && cc + 1 >= w)) begin
					for (j = 0; j < 3; j++) begin
						if (!(j == 0 && cr == 0) && !(j == 2 && cr + 1 >= h)) begin
							nbr = win[k][j];
							sum_r += nbr[23:16];
							sum_g += nbr[15:8];
							sum_b += nbr[7:0];
						end
					end
				end
			end
			// divisor stays nine at the border, so edges come out darker
			word.pixel  = {8'(sum_r / 9), 8'(sum_g / 9), 8'(sum_b / 9), ALPHA_OPAQUE};
			word.column = COL_BITS'(cc);
			word.row    = ROW_BITS'(cr);
			word.done   = (cc + 1 == w) && (cr + 1 == h);
			if (word.done) begin
				in_col = 0;
				in_row = 0;
			end
		end
	endtask

	// ---------------------------------------------------------------- stimulus helpers
	// mostly short pauses, now and then a long one
	function automatic int pick_pause(input int cap);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(4, cap);
	endfunction

	// stop offering, let every expected word out, then let the pipe run empty
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_blurs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// registers are only written with the block idle; any write restarts the frame
	task automatic write_register(input logic sel, input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == CFG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
		else height_reg = value[FH_W-1:0];
		in_col = 0;
		in_row = 0;
	endtask

	// offer one pixel word and hold it until taken; typed rows bring their own answer
	task automatic send_pixel(input logic [PIX_W-1:0] pixel, input logic flush,
			input logic typed, input blur_word_t want, input int gap);
		bit emits;
		blur_word_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pixel;
		s_axis_tuser  <= flush;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		blur_predict(pixel, flush, emits, predicted);
		if (typed) pending_blurs.push_back(want);
		else if (emits) pending_blurs.push_back(predicted);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random pixels from the start of a frame; items past the last row are mostly flushes,
	// the rest real pixels that the block has to treat as flushes
	task automatic stream_frame(input int item_count, input int gap_cap);
		int k, frame_items;
		logic flush;
		frame_items = eff_width() * eff_height();
		for (k = 0; k < item_count; k++) begin
			if (k >= frame_items) flush = ($urandom_range(0, 3) != 0);
			else flush = ($urandom_range(0, 19) == 0);
			send_pixel($urandom, flush, 1'b0, '0, burst ? 0 : pick_pause(gap_cap));
		end
	endtask

	// ---------------------------------------------------------------- result checking
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin : check_word
			blur_word_t got, want;
			got.pixel  = m_axis_tdata[PIX_W-1:0];
			got.column = m_axis_tdata[PIX_W +: COL_BITS];
			got.row    = m_axis_tdata[PIX_W + COL_BITS +: ROW_BITS];
			got.done   = m_axis_tlast;
			blurs_seen++;
			if (pending_blurs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: pixel %h col %0d row %0d done %0d",
						got.pixel, got.column, got.row, got.done);
			end else begin
				want = pending_blurs.pop_front();
				if (got.pixel !== want.pixel || got.column !== want.column ||
						got.row !== want.row || got.done !== want.done) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("word %0d: expected pixel %h col %0d row %0d done %0d, %s",
							blurs_seen, want.pixel, want.column, want.row, want.done,
							$sformatf("got pixel %h col %0d row %0d done %0d",
								got.pixel, got.column, got.row, got.done));
				end
			end
		end
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- result sink
	// random ready runs and stalls; once a long hold, right after the first word comes
	// out, so the pipe backs up to s_axis while the sender keeps offering
	initial begin : result_sink
		int run_len, stall_len, holds_done, n;
		holds_done = 0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (holds_done == 0 && blurs_seen >= 1) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			if ($urandom_range(0, 9) == 0) run_len = $urandom_range(50, 200);
			else run_len = $urandom_range(1, 12);
			m_axis_tready <= 1'b1;
			for (n = 0; n < run_len; n++) begin
				@(posedge clk);
				// cut the run short so the hold starts while the sender is busy
				if (holds_done == 0 && blurs_seen >= 1) break;
			end
			stall_len = pick_pause(20);
			if (stall_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- main sequence
	initial begin : stimulus
		directed_row_t table_rows[$];
		directed_row_t step;
		logic [PIX_W-1:0] white;
		int k, w, h, frames, f, total, random_sent;
		logic [CFG_W-1:0] width_value;

		for (k = 0; k < MAX_COLS; k++) begin
			upper_line[k] = '0;
			middle_line[k] = '0;
		end
		for (k = 0; k < 9; k++) win[k / 3][k % 3] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes, no register write yet: one row and a few dozen pixels of an
		// 800-wide frame, enough to see the first centres of row zero close out
		burst = 1'b0;
		stream_frame(RESET_WIDTH + 32, 3);

		// directed table
		white = 32'hFFFF_FFFF;
		// 3x3 all white: corners 4/9, edges 6/9, centre full
		table_rows.push_back('{1'b1, CFG_FRAME_WIDTH, 13'd3, '0, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b1, CFG_FRAME_HEIGHT, 13'd3, '0, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'hFFFF_FF00, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'hFFFF_FF00, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b1,
			'{32'h7171_71FF, 10'd0, 12'd0, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'hFFFF_FF00, 1'b0, 1'b1,
			'{32'hAAAA_AAFF, 10'd1, 12'd0, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b1,
			'{32'h7171_71FF, 10'd2, 12'd0, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'hFFFF_FF00, 1'b0, 1'b1,
			'{32'hAAAA_AAFF, 10'd0, 12'd1, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b1,
			'{32'hFFFF_FFFF, 10'd1, 12'd1, 1'b0}});
		// width+1 flush words drain the last row
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b1,
			'{32'hAAAA_AAFF, 10'd2, 12'd1, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b1,
			'{32'h7171_71FF, 10'd0, 12'd2, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b1,
			'{32'hAAAA_AAFF, 10'd1, 12'd2, 1'b0}});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b1,
			'{32'h7171_71FF, 10'd2, 12'd2, 1'b1}});
		// zero sizes saturate to a 1x1 frame: one pixel alone gives 255/9
		table_rows.push_back('{1'b1, CFG_FRAME_WIDTH, 13'd0, '0, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b1, CFG_FRAME_HEIGHT, 13'd0, '0, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'hFFFF_FF00, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b1,
			'{32'h1C1C_1CFF, 10'd0, 12'd0, 1'b1}});
		// 2x2 with masked high width bits, a flush inside the frame and real pixels after it
		table_rows.push_back('{1'b1, CFG_FRAME_WIDTH, 13'h1802, '0, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b1, CFG_FRAME_HEIGHT, 13'd2, '0, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'h0000_0000, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'h1234_5678, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, 32'hA5A5_A5A5, 1'b0, 1'b0, '0});
		table_rows.push_back('{1'b0, 1'b0, '0, white, 1'b1, 1'b0, '0});

		foreach (table_rows[k]) begin
			step = table_rows[k];
			if (step.write) write_register(step.sel, step.value);
			else send_pixel(step.pixel, step.flush, step.typed, step.want, pick_pause(20));
		end

		// random small frames, mostly whole ones back to back, some cut short
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			// bits above the width field are dropped by the block
			width_value = CFG_W'(w) | (CFG_W'($urandom_range(0, 3)) << FW_W);
			case ($urandom_range(0, 4))
				0: write_register(CFG_FRAME_WIDTH, width_value);
				1: write_register(CFG_FRAME_HEIGHT, CFG_W'(h));
				2: begin
					write_register(CFG_FRAME_HEIGHT, CFG_W'(h));
					write_register(CFG_FRAME_WIDTH, width_value);
				end
				default: begin
					write_register(CFG_FRAME_WIDTH, width_value);
					write_register(CFG_FRAME_HEIGHT, CFG_W'(h));
				end
			endcase
			burst = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				total = eff_width() * eff_height() + eff_width() + 1;
				// broken sequence: the last frame stops early and the next write restarts
				if (f == frames - 1 && total > 1 && $urandom_range(0, 6) == 0)
					total = $urandom_range(1, total - 1);
				stream_frame(total, 20);
				random_sent += total;
			end
		end

		wait_idle();
		if (mismatch_count == 0 && pending_blurs.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
